FILE: src/bclpd_pkg.sv
// ----------------------------------------------------------------------------
// bclpd_pkg
// Shared types and constants for the button click and long-press detector.
// ----------------------------------------------------------------------------
package bclpd_pkg;

  // Number of buttons served and field widths
  localparam int BUTTON_COUNT = 4;
  localparam int BTN_W        = 2;
  localparam int DCOUNT_W     = 4;
  localparam int TICK_W       = 16;
  localparam int REPEAT_W     = 8;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  // Register reset values
  localparam logic [DCOUNT_W-1:0] DEBOUNCE_SCANS_RST    = DCOUNT_W'(3);
  localparam logic [TICK_W-1:0]   LONG_PRESS_TICKS_RST  = TICK_W'(50);
  localparam logic [TICK_W-1:0]   RELEASE_GAP_TICKS_RST = TICK_W'(15);

  localparam logic [TICK_W-1:0]   TICK_MAX   = {TICK_W{1'b1}};
  localparam logic [REPEAT_W-1:0] REPEAT_MAX = {REPEAT_W{1'b1}};

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE_SCANS    = 2'd0,
    CFG_LONG_PRESS_TICKS  = 2'd1,
    CFG_RELEASE_GAP_TICKS = 2'd2
  } cfg_idx_t;

  // Press phase of one button
  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_PRESSED  = 2'd1,
    PH_RELEASED = 2'd2
  } phase_t;

  // Event codes
  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_LONG   = 2'd1,
    EV_SINGLE = 2'd2,
    EV_DOUBLE = 2'd3
  } event_t;

  // Configuration values seen by the datapath
  typedef struct packed {
    logic [DCOUNT_W-1:0] debounce_scans;
    logic [TICK_W-1:0]   long_press_ticks;
    logic [TICK_W-1:0]   release_gap_ticks;
  } cfg_t;

  // Per-button state
  typedef struct packed {
    logic                level;
    logic [DCOUNT_W-1:0] dcount;
    logic [TICK_W-1:0]   tick;
    logic [REPEAT_W-1:0] repeats;
    phase_t              phase;
  } btn_state_t;

  localparam btn_state_t BTN_STATE_RST = '{
    level:   1'b1,
    dcount:  '0,
    tick:    '0,
    repeats: '0,
    phase:   PH_IDLE
  };

endpackage

FILE: src/bclpd_item_if.sv
// ----------------------------------------------------------------------------
// bclpd_item_if
// Scan tick channel: one button index and its raw pin level per transaction.
// ----------------------------------------------------------------------------
interface bclpd_item_if import bclpd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [BTN_W-1:0] button_index;
  logic             raw_level;

  modport source (output valid, output button_index, output raw_level, input ready);
  modport sink   (input valid, input button_index, input raw_level, output ready);
endinterface

FILE: src/bclpd_result_if.sv
// ----------------------------------------------------------------------------
// bclpd_result_if
// Result channel: button index and event code per transaction.
// ----------------------------------------------------------------------------
interface bclpd_result_if import bclpd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [BTN_W-1:0] event_button;
  logic [1:0]       event_code;

  modport source (output valid, output event_button, output event_code, input ready);
  modport sink   (input valid, input event_button, input event_code, output ready);
endinterface

FILE: src/bclpd_cfg_if.sv
// ----------------------------------------------------------------------------
// bclpd_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface bclpd_cfg_if import bclpd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/bclpd_cfg_regs.sv
// ----------------------------------------------------------------------------
// bclpd_cfg_regs
// Configuration register file; takes a write transaction every cycle.
// ----------------------------------------------------------------------------
module bclpd_cfg_regs
  import bclpd_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  bclpd_cfg_if.sink      cfg,
  output cfg_t           cfg_q
);

  cfg_t regs;

  assign cfg.ready = 1'b1;
  assign cfg_q     = regs;

  // Write the addressed register; drop writes beyond the register list
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.debounce_scans    <= DEBOUNCE_SCANS_RST;
      regs.long_press_ticks  <= LONG_PRESS_TICKS_RST;
      regs.release_gap_ticks <= RELEASE_GAP_TICKS_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_DEBOUNCE_SCANS:    regs.debounce_scans    <= cfg.data[DCOUNT_W-1:0];
        CFG_LONG_PRESS_TICKS:  regs.long_press_ticks  <= cfg.data[TICK_W-1:0];
        CFG_RELEASE_GAP_TICKS: regs.release_gap_ticks <= cfg.data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: src/bclpd_btn_step.sv
// ----------------------------------------------------------------------------
// bclpd_btn_step
// Next-state logic for one button on one scan tick: debounce, tick counter
// and press phase machine, plus the event it raises.
// ----------------------------------------------------------------------------
module bclpd_btn_step
  import bclpd_pkg::*;
(
  input  cfg_t       cfg_q,
  input  btn_state_t cur,
  input  logic       raw_level,
  output btn_state_t nxt,
  output event_t     ev
);

  logic [TICK_W-1:0]   tick_inc;
  logic [DCOUNT_W-1:0] dcount_inc;
  logic                level_new;
  logic [DCOUNT_W-1:0] dcount_new;

  // Advance the tick counter outside idle, saturating at the top
  always_comb begin
    tick_inc = cur.tick;
    if (cur.phase != PH_IDLE && cur.tick != TICK_MAX) begin
      tick_inc = cur.tick + TICK_W'(1);
    end
  end

  // Debounce: flip the level after enough consecutive differing scans
  always_comb begin
    dcount_inc = cur.dcount + DCOUNT_W'(1);
    level_new  = cur.level;
    dcount_new = '0;
    if (raw_level != cur.level) begin
      if (dcount_inc >= cfg_q.debounce_scans) begin
        level_new = raw_level;
      end else begin
        dcount_new = dcount_inc;
      end
    end
  end

  // Press phase machine
  always_comb begin
    nxt        = cur;
    nxt.level  = level_new;
    nxt.dcount = dcount_new;
    nxt.tick   = tick_inc;
    ev         = EV_NONE;
    unique case (cur.phase)
      PH_PRESSED: begin
        if (level_new) begin
          nxt.tick  = '0;
          nxt.phase = PH_RELEASED;
        end else if (tick_inc > cfg_q.long_press_ticks) begin
          ev          = EV_LONG;
          nxt.tick    = '0;
          nxt.repeats = '0;
        end
      end
      PH_RELEASED: begin
        if (tick_inc > cfg_q.release_gap_ticks) begin
          if (cur.repeats == REPEAT_W'(1)) begin
            ev = EV_SINGLE;
          end else if (cur.repeats == REPEAT_W'(2)) begin
            ev = EV_DOUBLE;
          end
          nxt.phase = PH_IDLE;
        end else if (!level_new) begin
          if (cur.repeats != REPEAT_MAX) begin
            nxt.repeats = cur.repeats + REPEAT_W'(1);
          end
          nxt.tick  = '0;
          nxt.phase = PH_PRESSED;
        end
      end
      default: begin
        // Idle, and the unused phase code handled as idle
        if (!level_new) begin
          nxt.tick    = '0;
          nxt.repeats = REPEAT_W'(1);
          nxt.phase   = PH_PRESSED;
        end
      end
    endcase
  end

endmodule

FILE: src/button_click_long_press_detector_top.sv
// ----------------------------------------------------------------------------
// button_click_long_press_detector_top
// Debounce, click and long-press detection for a bank of active-low buttons.
// ----------------------------------------------------------------------------
// Usage:
//   item   - scan tick transaction: button_index and raw_level (0 = pressed).
//   result - one transaction per scan tick: event_button and event_code
//            (0 none, 1 long press, 2 single click, 3 double click).
//   cfg    - register writes: 0 debounce_scans, 1 long_press_ticks,
//            2 release_gap_ticks; other indexes are ignored. Write only
//            while no tick is in flight.
// Timing:
//   An accepted tick is held in the input register, its per-button state
//   update and event are computed in one pass and the result is then
//   captured in the output register.
//   One tick is taken every cycle unless the result side stalls; the rate
//   is set by the single pass through the per-button state registers.
// Reset (synchronous, active high) restores the register defaults and
//   clears every button to released and idle. When the result receiver
//   stalls, the output register and the input register both hold and item
//   ready drops only once both are full.
// ----------------------------------------------------------------------------
module button_click_long_press_detector_top
  import bclpd_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  bclpd_item_if.sink      item,
  bclpd_result_if.source  result,
  bclpd_cfg_if.sink       cfg
);

  cfg_t             cfg_q;
  btn_state_t       state [BUTTON_COUNT];
  btn_state_t       cur;
  btn_state_t       nxt;
  event_t           ev;
  logic             in_range;
  logic             advance;

  logic             s1_valid;
  logic [BTN_W-1:0] s1_index;
  logic             s1_raw;

  logic             out_valid;
  logic [BTN_W-1:0] out_button;
  event_t           out_code;

  bclpd_cfg_regs u_cfg_regs (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .cfg_q (cfg_q)
  );

  // Stage and output handshake
  assign advance    = !out_valid || result.ready;
  assign item.ready = !s1_valid || advance;

  // Hold the accepted tick in the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      s1_index <= item.button_index;
      s1_raw   <= item.raw_level;
    end
  end

  // Look up the addressed button's state
  assign in_range = int'(s1_index) < BUTTON_COUNT;
  assign cur      = state[s1_index];

  bclpd_btn_step u_btn_step (
    .cfg_q     (cfg_q),
    .cur       (cur),
    .raw_level (s1_raw),
    .nxt       (nxt),
    .ev        (ev)
  );

  // Write back the button state as the tick moves to the output
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BUTTON_COUNT; i++) begin
        state[i] <= BTN_STATE_RST;
      end
    end else if (s1_valid && advance && in_range) begin
      state[s1_index] <= nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      out_button <= s1_index;
      out_code   <= in_range ? ev : EV_NONE;
    end
  end

  assign result.valid        = out_valid;
  assign result.event_button = out_button;
  assign result.event_code   = out_code;

endmodule

FILE: tb/bclpd_event_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bclpd_event_monitor
// Watches the scan tick, result and register write channels of the button
// detector. It tracks debounce, tick and press counts for every button and
// compares each result transaction, field by field, with the event expected
// for the oldest scan tick that has not been answered yet.
// ----------------------------------------------------------------------------
module bclpd_event_monitor
  import bclpd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  bclpd_item_if   item,
  bclpd_result_if result,
  bclpd_cfg_if    cfg,
  output int      fail_count,
  output int      events_due,
  output int      long_seen,
  output int      single_seen,
  output int      double_seen
);

  typedef struct packed {
    logic [BTN_W-1:0] button;
    event_t           code;
  } button_event_t;

  // Register copies
  logic [DCOUNT_W-1:0] scans_cfg;
  logic [TICK_W-1:0]   long_cfg;
  logic [TICK_W-1:0]   gap_cfg;

  // Per-button tracking state
  logic                level   [BUTTON_COUNT];
  logic [DCOUNT_W-1:0] bounce  [BUTTON_COUNT];
  logic [TICK_W-1:0]   ticks   [BUTTON_COUNT];
  logic [REPEAT_W-1:0] presses [BUTTON_COUNT];
  phase_t              phase   [BUTTON_COUNT];

  button_event_t due_events [$];
  button_event_t want;
  int            misses  = 0;
  int            longs   = 0;
  int            singles = 0;
  int            doubles = 0;

  assign fail_count  = misses;
  assign long_seen   = longs;
  assign single_seen = singles;
  assign double_seen = doubles;

  // Advance one button by one scan tick and return the event it gives
  function automatic event_t next_button_event(input int unsigned b, input logic raw);
    event_t              ev;
    logic [DCOUNT_W-1:0] cnt;
    ev = EV_NONE;
    if (b >= BUTTON_COUNT) return EV_NONE;

    if (phase[b] != PH_IDLE && ticks[b] != TICK_MAX) ticks[b] = ticks[b] + TICK_W'(1);

    // debounce: level follows raw after enough differing scans in a row
    if (raw != level[b]) begin
      cnt = bounce[b] + DCOUNT_W'(1);
      if (cnt >= scans_cfg) begin
        level[b] = raw;
        cnt = '0;
      end
      bounce[b] = cnt;
    end else begin
      bounce[b] = '0;
    end

    case (phase[b])
      PH_PRESSED: begin
        if (level[b]) begin
          ticks[b] = '0;
          phase[b] = PH_RELEASED;
        end else if (ticks[b] > long_cfg) begin
          ev = EV_LONG;
          ticks[b] = '0;
          presses[b] = '0;
        end
      end
      PH_RELEASED: begin
        if (ticks[b] > gap_cfg) begin
          if (presses[b] == REPEAT_W'(1)) ev = EV_SINGLE;
          else if (presses[b] == REPEAT_W'(2)) ev = EV_DOUBLE;
          phase[b] = PH_IDLE;
        end else if (!level[b]) begin
          if (presses[b] != REPEAT_MAX) presses[b] = presses[b] + REPEAT_W'(1);
          ticks[b] = '0;
          phase[b] = PH_PRESSED;
        end
      end
      default: begin
        if (!level[b]) begin
          ticks[b] = '0;
          presses[b] = REPEAT_W'(1);
          phase[b] = PH_PRESSED;
        end
      end
    endcase
    return ev;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      scans_cfg = DEBOUNCE_SCANS_RST;
      long_cfg  = LONG_PRESS_TICKS_RST;
      gap_cfg   = RELEASE_GAP_TICKS_RST;
      for (int i = 0; i < BUTTON_COUNT; i++) begin
        level[i]   = 1'b1;
        bounce[i]  = '0;
        ticks[i]   = '0;
        presses[i] = '0;
        phase[i]   = PH_IDLE;
      end
      due_events.delete();
    end else begin
      // track register writes
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_DEBOUNCE_SCANS:    scans_cfg = cfg.data[DCOUNT_W-1:0];
          CFG_LONG_PRESS_TICKS:  long_cfg  = cfg.data;
          CFG_RELEASE_GAP_TICKS: gap_cfg   = cfg.data;
          default: ;
        endcase
      end

      // queue the event expected for each accepted scan tick
      if (item.valid && item.ready) begin
        want.button = item.button_index;
        want.code   = next_button_event(item.button_index, item.raw_level);
        due_events.push_back(want);
      end

      // compare each result transaction with the oldest expectation
      if (result.valid && result.ready) begin
        if (due_events.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, got button %0d event %0d",
                   $time, result.event_button, result.event_code);
          misses++;
        end else begin
          want = due_events.pop_front();
          if (result.event_button !== want.button) begin
            $display("%0t ns: event_button mismatch, expected %0d, got %0d",
                     $time, want.button, result.event_button);
            misses++;
          end
          if (result.event_code !== want.code) begin
            $display("%0t ns: event_code mismatch on button %0d, expected %0d, got %0d",
                     $time, want.button, want.code, result.event_code);
            misses++;
          end
          case (want.code)
            EV_LONG:   longs++;
            EV_SINGLE: singles++;
            EV_DOUBLE: doubles++;
            default: ;
          endcase
        end
      end
    end
    events_due <= due_events.size();
  end

endmodule

FILE: tb/tb_button_click_long_press_detector_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_click_long_press_detector_top
// Drives scan ticks and register writes into the button detector, stalls the
// result side at random and gives the verdict. A short directed sequence
// covers bounce, single and double clicks, long press and triple presses;
// a run of quick presses on one button drives the press counter into
// saturation; random press and release sequences with noise run under
// several register settings.
// ----------------------------------------------------------------------------
module tb_button_click_long_press_detector_top;
  import bclpd_pkg::*;

  localparam int PERIOD         = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic clk        = 1'b0;
  logic rst        = 1'b1;
  logic take_ready = 1'b1;

  int stall_left = 0;
  int stall_pct  = 0;
  int gap_pct    = 0;
  int idle_run   = 0;

  int scans_now, long_now, gap_now;
  int sent          = 0;
  int settings_used = 0;
  int hold_left  [BUTTON_COUNT];
  logic want_level [BUTTON_COUNT];

  int fail_count, events_due, long_seen, single_seen, double_seen;

  bclpd_item_if   item_ch ();
  bclpd_result_if result_ch ();
  bclpd_cfg_if    cfg_ch ();

  assign result_ch.ready = take_ready;

  always #(PERIOD / 2) clk = ~clk;

  button_click_long_press_detector_top dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  bclpd_event_monitor monitor (
    .clk         (clk),
    .rst         (rst),
    .item        (item_ch),
    .result      (result_ch),
    .cfg         (cfg_ch),
    .fail_count  (fail_count),
    .events_due  (events_due),
    .long_seen   (long_seen),
    .single_seen (single_seen),
    .double_seen (double_seen)
  );

  // Stall the result side in bursts of random length
  always @(posedge clk) begin
    if (stall_left != 0) begin
      take_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
      take_ready <= 1'b0;
      stall_left <= $urandom_range(7);
    end else begin
      take_ready <= 1'b1;
    end
  end

  // Abort when no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_run <= 0;
    end else if (idle_run >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d cycles without a transaction", idle_run);
      $display("tb: failure");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  // Send one scan tick, with an optional idle burst in front
  task automatic send_scan(input logic [BTN_W-1:0] b, input logic raw);
    int idle_n;
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      idle_n = $urandom_range(8, 1);
      item_ch.valid <= 1'b0;
      repeat (idle_n) @(posedge clk);
    end
    item_ch.valid        <= 1'b1;
    item_ch.button_index <= b;
    item_ch.raw_level    <= raw;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    sent++;
  endtask

  // One register write transaction; the caller lowers valid afterwards
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  // Drain all outstanding results, then load a new register setting
  task automatic apply_settings(input int scans, input int hold_lim, input int gap_lim);
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (events_due != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    // upper data bits are random: only the low bits reach the debounce register
    write_reg(CFG_DEBOUNCE_SCANS, CFG_DATA_W'(($urandom_range(4095) << DCOUNT_W) | scans));
    write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
    write_reg(CFG_LONG_PRESS_TICKS, CFG_DATA_W'(hold_lim));
    write_reg(CFG_RELEASE_GAP_TICKS, CFG_DATA_W'(gap_lim));
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    scans_now = (scans == 0) ? 1 : scans;
    long_now  = hold_lim;
    gap_now   = gap_lim;
    settings_used++;
  endtask

  // Random press and release sequences with bounce noise on all buttons
  task automatic run_random(input int count, input int idle_pct, input int hold_pct);
    int   b;
    int   focus;
    logic raw;
    gap_pct   = idle_pct;
    stall_pct = hold_pct;
    focus     = $urandom_range(BUTTON_COUNT - 1);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(31) == 0) focus = $urandom_range(BUTTON_COUNT - 1);
      b = $urandom_range(1) ? focus : $urandom_range(BUTTON_COUNT - 1);
      // pick the next hold length: bounce, short, long press or past the gap
      if (hold_left[b] == 0) begin
        want_level[b] = ~want_level[b];
        case ($urandom_range(3))
          0: hold_left[b] = $urandom_range(scans_now + 1, 1);
          1: hold_left[b] = $urandom_range(scans_now + gap_now, scans_now + 1);
          2: hold_left[b] = $urandom_range(scans_now + 2 * long_now + 3, scans_now + long_now);
          default: hold_left[b] = $urandom_range(scans_now + gap_now + 6, scans_now + gap_now + 1);
        endcase
      end
      hold_left[b]--;
      raw = want_level[b];
      if ($urandom_range(99) < 6) raw = ~raw;
      send_scan(BTN_W'(b), raw);
    end
  endtask

  initial begin
    item_ch.valid        <= 1'b0;
    item_ch.button_index <= '0;
    item_ch.raw_level    <= 1'b1;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.index         <= '0;
    cfg_ch.data          <= '0;
    for (int i = 0; i < BUTTON_COUNT; i++) begin
      hold_left[i]  = 0;
      want_level[i] = 1'b1;
    end
    scans_now = 3;
    long_now  = 50;
    gap_now   = 15;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: broken bounce, then a clean press and release on button 0
    send_scan(0, 0); send_scan(0, 1); send_scan(0, 0); send_scan(0, 0); send_scan(0, 0);
    send_scan(2, 0);
    send_scan(0, 1); send_scan(0, 1); send_scan(0, 1);

    // lowest limits: single, double, long press and triple press
    apply_settings(1, 1, 1);
    send_scan(0, 1); send_scan(0, 1);
    send_scan(1, 0); send_scan(1, 1); send_scan(1, 0); send_scan(1, 1); send_scan(1, 1);
    send_scan(1, 1);
    send_scan(2, 0); send_scan(2, 0); send_scan(2, 0); send_scan(2, 1); send_scan(2, 1);
    send_scan(2, 1);
    send_scan(3, 0); send_scan(3, 1); send_scan(3, 0); send_scan(3, 1); send_scan(3, 0);
    send_scan(3, 1); send_scan(3, 1); send_scan(3, 1);

    // random phases under varied settings
    apply_settings(3, 50, 15);
    run_random(250, 20, 20);
    apply_settings(1, 1, 1);
    run_random(200, 0, 0);
    apply_settings(15, 30, 40);
    run_random(150, 30, 30);
    apply_settings(0, 4, 3);
    run_random(200, 10, 40);

    // press counter saturation on button 0: settle to idle, then press often
    // enough inside the gap that a wrapping press count would read one
    gap_pct   = 0;
    stall_pct = 0;
    apply_settings(1, 1, 1);
    repeat (4) send_scan(0, 1);
    apply_settings(1, 65535, 8);
    repeat (257) begin
      send_scan(0, 0);
      send_scan(0, 1);
    end
    repeat (10) send_scan(0, 1);
    want_level[0] = 1'b1;
    hold_left[0]  = 0;

    apply_settings(2, 8, 5);
    run_random(200, 40, 10);
    // last part without idling on either side
    apply_settings(2, 6, 4);
    run_random(250, 0, 0);

    // wait for the tail of results
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (events_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("run covered %0d scan ticks under %0d register settings, incl. counter saturation",
             sent, settings_used);
    $display("events checked: %0d long presses, %0d single clicks, %0d double clicks",
             long_seen, single_seen, double_seen);
    if (fail_count == 0 && events_due == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
